// File: hw/rtl/ansi_text_terminal_assert.svh
// Assertion macros shared by the terminal RTL.
`ifndef ANSI_TEXT_TERMINAL_ASSERT_SVH
`define ANSI_TEXT_TERMINAL_ASSERT_SVH
// A condition that must hold at every clock edge out of reset.
`define ATT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// An implication checked in the same clock edge.
`define ATT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

// File: hw/rtl/att_pkg.sv
// Shared types and constants of the text terminal.
`default_nettype none
package att_pkg;
  // Wide enough for the largest screen the parameters allow.
  localparam int CELL_AW = 12;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_FF     = 8'd12;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_TILDE  = 8'd126;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CSI_CUU   = 8'h41;
  localparam logic [7:0] CSI_CUD   = 8'h42;
  localparam logic [7:0] CSI_CUF   = 8'h43;
  localparam logic [7:0] CSI_CUB   = 8'h44;
  localparam logic [7:0] CSI_CNL   = 8'h45;
  localparam logic [7:0] CSI_CPL   = 8'h46;
  localparam logic [7:0] CSI_CHA   = 8'h47;
  localparam logic [7:0] CSI_CUP   = 8'h48;
  localparam logic [7:0] CSI_ED    = 8'h4A;
  localparam logic [7:0] CSI_EL    = 8'h4B;
  localparam logic [15:0] RESET_CELL = 16'h0720;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [15:0] PARAM_LIMIT = 16'hFFFF;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  typedef enum logic [3:0] {
    PM_NORMAL = 4'b0001,
    PM_ESCAPE = 4'b0010,
    PM_SQUARE = 4'b0100,
    PM_PARAMS = 4'b1000
  } att_mode_t;

  typedef enum logic [5:0] {
    BK_CLEAR = 6'b000001,
    BK_IDLE  = 6'b000010,
    BK_COPY  = 6'b000100,
    BK_FILL  = 6'b001000,
    BK_READ  = 6'b010000,
    BK_DONE  = 6'b100000
  } att_bstate_t;

  typedef struct packed {
    logic               do_write;
    logic               do_scroll;
    logic               do_fill;
    logic               do_read;
    logic               rd_ok;
    logic [CELL_AW-1:0] addr;
    logic [CELL_AW-1:0] first;
    logic [CELL_AW-1:0] last;
    logic [15:0]        wdata;
    logic [6:0]         col;
    logic [4:0]         row;
    logic [10:0]        idx;
  } att_cmd_t;
endpackage
`default_nettype wire

// File: hw/rtl/ansi_text_terminal.sv
// An erase walks the blanked cells one by one and a scroll copies the screen up a
// row and then blanks the bottom row, both through the single write port of the
// screen memory.
// Throughput: the back end is the limit; items queue up while it is busy until the queue is full.
// Reset: synchronous active-low; afterwards a clearing pass fills the screen with
// 0x0720, during which in_full is high.
`default_nettype none
module ansi_text_terminal import att_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int MAX_PARAMS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: the attribute byte for printed characters and blanks.
  input  wire logic        cfg_write_en,
  input  wire logic [7:0]  cfg_text_attribute,
  // Input channel: a transfer happens when push is high and full is low.
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_char_byte,
  input  wire logic [10:0] in_cell_address,
  // Result channel: a transfer happens when pop is high and empty is low.
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [6:0]       out_cursor_col,
  output logic [4:0]       out_cursor_row,
  output logic [10:0]      out_cursor_index,
  output logic [15:0]      out_cell_data
);
  // The front end parses each byte and tracks the cursor combinationally, so every
  // command already carries the cursor position that its result reports.
  // The back end owns the screen memory and walks erases and scrolls cell by cell.
  logic [7:0] attr_r;
  att_cmd_t   f_cmd, q_head;
  logic       q_push, q_full, q_pop, q_empty, back_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_write_en) begin
      attr_r <= cfg_text_attribute;
    end
  end

  att_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .MAX_PARAMS     (MAX_PARAMS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .attr            (attr_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_action       (in_action),
    .in_char_byte    (in_char_byte),
    .in_cell_address (in_cell_address),
    .back_ready      (back_ready),
    .q_full          (q_full),
    .q_push          (q_push),
    .cmd             (f_cmd)
  );

  // Two commands of slack let the parser run on while a sweep is in progress.
  att_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (f_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // The result register sits in the back end, so a waiting result does not stop
  // the next command from being taken.
  att_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .attr             (attr_r),
    .q_empty          (q_empty),
    .q_cmd            (q_head),
    .q_pop            (q_pop),
    .ready            (back_ready),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_cursor_col   (out_cursor_col),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_index (out_cursor_index),
    .out_cell_data    (out_cell_data)
  );
endmodule
`default_nettype wire

// File: hw/rtl/att_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module att_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/att_front.sv
// Byte parser and cursor tracker that turns items into screen commands.
`default_nettype none
module att_front import att_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25,
  parameter int MAX_PARAMS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [7:0]   attr,
  input  wire logic         in_push,
  output logic              in_full,
  input  wire logic         in_action,
  input  wire logic [7:0]   in_char_byte,
  input  wire logic [10:0]  in_cell_address,
  input  wire logic         back_ready,
  input  wire logic         q_full,
  output logic              q_push,
  output att_cmd_t          cmd
);
  localparam int SW = $clog2(MAX_PARAMS);
  localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_PARAMS - 1);
  localparam logic [7:0] COLS8 = 8'(SCREEN_COLUMNS);
  localparam logic [5:0] ROWS6 = 6'(SCREEN_ROWS);
  localparam logic [CELL_AW-1:0] NCELL = CELL_AW'(SCREEN_COLUMNS * SCREEN_ROWS);
  localparam logic [CELL_AW-1:0] COLS_A = CELL_AW'(SCREEN_COLUMNS);
  localparam logic signed [18:0] COLS_S = 19'(SCREEN_COLUMNS);
  localparam logic signed [18:0] ROWS_S = 19'(SCREEN_ROWS);

  att_mode_t      mode_r, mode_nxt;
  logic [6:0]     col_r, col_nxt;
  logic [4:0]     row_r, row_nxt;
  logic [SW-1:0]  slot_r, slot_nxt;
  logic [15:0]    pv_r [MAX_PARAMS];
  logic [15:0]    pv_nxt [MAX_PARAMS];
  logic           accept;

  assign in_full = q_full || !back_ready;
  assign accept  = in_push && !in_full;
  assign q_push  = accept;

  always_comb begin
    logic [7:0]          c;
    logic [7:0]          col_t;
    logic [5:0]          row_t;
    logic [CELL_AW-1:0]  here;
    logic [CELL_AW-1:0]  line;
    logic                sq;
    logic [SW-1:0]       slot_e;
    logic [15:0]         p;
    logic [15:0]         q;
    logic [16:0]         d;
    logic [16:0]         e;
    logic [19:0]         acc;
    logic signed [18:0]  xs;
    logic signed [18:0]  ys;
    logic signed [18:0]  ds;
    logic signed [18:0]  tx;
    logic signed [18:0]  ty;
    logic                mv;
    c        = in_char_byte;
    mode_nxt = mode_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    slot_nxt = slot_r;
    sq       = (mode_r == PM_SQUARE);
    slot_e   = sq ? '0 : slot_r;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      pv_nxt[i] = sq ? 16'd0 : pv_r[i];
    end
    p     = pv_nxt[0];
    q     = pv_nxt[1];
    d     = (p == 16'd0) ? 17'd1 : {1'b0, p};
    e     = (q == 16'd0) ? 17'd1 : {1'b0, q};
    acc   = 20'(pv_nxt[slot_e]) * 20'd10 + 20'(c - CH_ZERO);
    here  = CELL_AW'(row_r * SCREEN_COLUMNS) + CELL_AW'(col_r);
    line  = CELL_AW'(row_r * SCREEN_COLUMNS);
    xs    = 19'(col_r);
    ys    = 19'(row_r);
    ds    = 19'(d);
    tx    = xs;
    ty    = ys;
    mv    = 1'b0;
    col_t = {1'b0, col_r};
    row_t = {1'b0, row_r};
    cmd   = '0;
    if (in_action) begin
      cmd.do_read = 1'b1;
      cmd.addr    = CELL_AW'(in_cell_address);
      cmd.rd_ok   = CELL_AW'(in_cell_address) < NCELL;
    end else begin
      unique case (mode_r)
        PM_NORMAL: begin
          if (c >= CH_SPACE && c <= CH_TILDE) begin
            cmd.do_write = 1'b1;
            cmd.addr     = here;
            cmd.wdata    = {attr, c};
            col_t        = col_t + 8'd1;
          end else if (c == CH_TAB) begin
            col_t = (col_t | 8'd7) + 8'd1;
          end else if (c >= CH_LF && c <= CH_FF) begin
            row_t = row_t + 6'd1;
          end else if (c == CH_ESC) begin
            mode_nxt = PM_ESCAPE;
          end else if (c == CH_CR) begin
            col_t = 8'd0;
          end else if (c == CH_DEL && col_r != 7'd0) begin
            col_t        = col_t - 8'd1;
            cmd.do_write = 1'b1;
            cmd.addr     = here - CELL_AW'(1);
            cmd.wdata    = {attr, BLANK_CHAR};
          end
          if (col_t >= COLS8) begin
            col_t = col_t - COLS8;
            row_t = row_t + 6'd1;
          end
          if (row_t >= ROWS6) begin
            row_t         = ROWS6 - 6'd1;
            cmd.do_scroll = 1'b1;
          end
          col_nxt = col_t[6:0];
          row_nxt = row_t[4:0];
        end
        PM_ESCAPE: begin
          mode_nxt = (c == CH_LBRACK) ? PM_SQUARE : PM_NORMAL;
        end
        PM_SQUARE, PM_PARAMS: begin
          mode_nxt = PM_PARAMS;
          slot_nxt = slot_e;
          if (c == CH_SEMI && slot_e != SLOT_LAST) begin
            slot_nxt = slot_e + SW'(1);
          end else if (c >= CH_ZERO && c <= CH_NINE) begin
            pv_nxt[slot_e] = (acc > 20'(PARAM_LIMIT)) ? PARAM_LIMIT : acc[15:0];
          end else begin
            mode_nxt = PM_NORMAL;
            if (c == CSI_CUU) begin
              ty = ys - ds; mv = 1'b1;
            end else if (c == CSI_CUD) begin
              ty = ys + ds; mv = 1'b1;
            end else if (c == CSI_CUF) begin
              tx = xs + ds; mv = 1'b1;
            end else if (c == CSI_CUB) begin
              tx = xs - ds; mv = 1'b1;
            end else if (c == CSI_CNL) begin
              tx = '0; ty = ys + ds; mv = 1'b1;
            end else if (c == CSI_CPL) begin
              tx = '0; ty = ys - ds; mv = 1'b1;
            end else if (c == CSI_CHA) begin
              tx = ds - 19'sd1; mv = 1'b1;
            end else if (c == CSI_CUP) begin
              tx = 19'(e) - 19'sd1; ty = ds - 19'sd1; mv = 1'b1;
            end else if (c == CSI_ED) begin
              cmd.do_fill = (p <= 16'd2);
              cmd.first   = (p == 16'd0) ? here : '0;
              cmd.last    = (p == 16'd1) ? here : NCELL - CELL_AW'(1);
            end else if (c == CSI_EL) begin
              cmd.do_fill = (p <= 16'd2);
              cmd.first   = (p == 16'd0) ? here : line;
              cmd.last    = (p == 16'd1) ? here : line + COLS_A - CELL_AW'(1);
            end
            if (mv && tx >= 0 && tx < COLS_S && ty >= 0 && ty < ROWS_S) begin
              col_nxt = tx[6:0];
              row_nxt = ty[4:0];
            end
          end
        end
        default: begin
          mode_nxt = PM_NORMAL;
        end
      endcase
    end
    cmd.col = col_nxt;
    cmd.row = row_nxt;
    cmd.idx = 11'(row_nxt * SCREEN_COLUMNS + 32'(col_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PM_NORMAL;
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        pv_r[i] <= '0;
      end
    end else if (accept) begin
      mode_r <= mode_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        pv_r[i] <= pv_nxt[i];
      end
    end
  end

`include "ansi_text_terminal_assert.svh"
  `ATT_ASSERT_ALWAYS(a_cursor_on_screen, (col_r < COLS8[6:0] && 32'(row_r) < SCREEN_ROWS), "cursor off screen")
endmodule
`default_nettype wire

// File: hw/rtl/att_cmdq.sv
// Short command queue between the parser and the screen engine.
`default_nettype none
module att_cmdq import att_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  att_cmd_t  push_cmd,
  output logic      full,
  input  wire logic pop,
  output att_cmd_t  head,
  output logic      empty
);
  localparam int PW = $clog2(CMDQ_DEPTH);

  att_cmd_t        slots [CMDQ_DEPTH];
  logic [PW-1:0]   wp_r, rp_r;
  logic [PW:0]     cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(CMDQ_DEPTH));
  assign head  = slots[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

`include "ansi_text_terminal_assert.svh"
  `ATT_ASSERT_ALWAYS(a_cmdq_count, (cnt_r <= (PW+1)'(CMDQ_DEPTH)), "command queue overflow")
endmodule
`default_nettype wire

// File: hw/rtl/att_back.sv
// Screen engine: runs cell writes, erases, scrolls and reads, holds the result.
`default_nettype none
module att_back import att_pkg::*; #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [7:0]   attr,
  input  wire logic         q_empty,
  input  att_cmd_t          q_cmd,
  output logic              q_pop,
  output logic              ready,
  output logic              out_empty,
  input  wire logic         out_pop,
  output logic [6:0]        out_cursor_col,
  output logic [4:0]        out_cursor_row,
  output logic [10:0]       out_cursor_index,
  output logic [15:0]       out_cell_data
);
  localparam int NCELLS = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int RAW = $clog2(NCELLS);
  localparam logic [CELL_AW-1:0] NLAST = CELL_AW'(NCELLS - 1);
  localparam logic [CELL_AW-1:0] MCOPY = CELL_AW'(SCREEN_COLUMNS * (SCREEN_ROWS - 1));
  localparam logic [CELL_AW-1:0] COLS_A = CELL_AW'(SCREEN_COLUMNS);

  att_bstate_t        st_r, st_nxt;
  att_cmd_t           cmd_r;
  logic [CELL_AW-1:0] cur_r, cur_nxt;
  logic [CELL_AW-1:0] last_r, last_nxt;
  logic [CELL_AW-1:0] pidx_r, pidx_nxt;
  logic               pend_r, pend_nxt;
  logic [15:0]        fdata_r, fdata_nxt;
  logic [15:0]        rdat_r, rdat_nxt;
  logic               ov_r, ov_nxt;
  logic               load_out;
  logic               we;
  logic [CELL_AW-1:0] waddr, raddr;
  logic [15:0]        wdata, rdata;

  att_ram #(.WIDTH(16), .DEPTH(NCELLS)) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr[RAW-1:0]),
    .wdata (wdata),
    .raddr (raddr[RAW-1:0]),
    .rdata (rdata)
  );

  assign ready     = (st_r != BK_CLEAR);
  assign out_empty = !ov_r;

  always_comb begin
    st_nxt    = st_r;
    cur_nxt   = cur_r;
    last_nxt  = last_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = 1'b0;
    fdata_nxt = fdata_r;
    rdat_nxt  = rdat_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    waddr     = cur_r;
    wdata     = fdata_r;
    raddr     = cur_r;
    load_out  = 1'b0;
    ov_nxt    = ov_r && !out_pop;
    unique case (st_r)
      BK_CLEAR: begin
        we    = 1'b1;
        wdata = RESET_CELL;
        cur_nxt = cur_r + CELL_AW'(1);
        if (cur_r == NLAST) begin
          st_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          we        = q_cmd.do_write;
          waddr     = q_cmd.addr;
          wdata     = q_cmd.wdata;
          raddr     = q_cmd.addr;
          rdat_nxt  = '0;
          fdata_nxt = {attr, BLANK_CHAR};
          priority if (q_cmd.do_scroll) begin
            cur_nxt = '0;
            st_nxt  = BK_COPY;
          end else if (q_cmd.do_fill) begin
            cur_nxt  = q_cmd.first;
            last_nxt = q_cmd.last;
            st_nxt   = BK_FILL;
          end else if (q_cmd.do_read) begin
            st_nxt = BK_READ;
          end else begin
            st_nxt = BK_DONE;
          end
        end
      end
      BK_COPY: begin
        // Read one row ahead while the previous read lands one row up.
        raddr = cur_r + COLS_A;
        if (cur_r != MCOPY) begin
          cur_nxt  = cur_r + CELL_AW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = cur_r;
        end
        if (pend_r) begin
          we    = 1'b1;
          waddr = pidx_r;
          wdata = rdata;
        end
        if (cur_r == MCOPY && !pend_r) begin
          last_nxt = NLAST;
          st_nxt   = BK_FILL;
        end
      end
      BK_FILL: begin
        we      = 1'b1;
        cur_nxt = cur_r + CELL_AW'(1);
        if (cur_r == last_r) begin
          st_nxt = BK_DONE;
        end
      end
      BK_READ: begin
        rdat_nxt = cmd_r.rd_ok ? rdata : 16'd0;
        st_nxt   = BK_DONE;
      end
      BK_DONE: begin
        if (!ov_r || out_pop) begin
          load_out = 1'b1;
          ov_nxt   = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_CLEAR;
      cur_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cur_r  <= cur_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r  <= last_nxt;
    pidx_r  <= pidx_nxt;
    fdata_r <= fdata_nxt;
    rdat_r  <= rdat_nxt;
    if (q_pop) begin
      cmd_r <= q_cmd;
    end
    if (load_out) begin
      out_cursor_col   <= cmd_r.col;
      out_cursor_row   <= cmd_r.row;
      out_cursor_index <= cmd_r.idx;
      out_cell_data    <= rdat_r;
    end
  end

`include "ansi_text_terminal_assert.svh"
  `ATT_ASSERT_IMPL(a_copy_complete, (st_r == BK_COPY && st_nxt == BK_FILL), (cur_r == MCOPY), "scroll copy ended early")
  `ATT_ASSERT_IMPL(a_no_result_in_clear, (st_r == BK_CLEAR), (!ov_r && !q_pop), "activity during clearing pass")
  `ATT_ASSERT_IMPL(a_write_in_range, we, (waddr <= NLAST), "screen write out of range")
endmodule
`default_nettype wire
